### rtl/bts_pkg.sv
// Shared types, constants and axis arithmetic for the bilinear texture sampler.
package bts_pkg;

	localparam int MAX_DIM         = 128;
	localparam int COORD_FRAC_BITS = 16;
	localparam int WEIGHT_BITS     = 8;
	localparam int TEXEL_COUNT_DEF = 16384;

	localparam int IDX_W     = 14;
	localparam int TEXEL_W   = 32;
	localparam int COORD_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int CHANNELS  = 4;
	localparam int CFG_W     = 8;
	localparam int REG_IDX_W = 2;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int FRAC_W = COORD_FRAC_BITS;
	localparam int WGT_W  = WEIGHT_BITS;
	localparam int LIN_W  = 2 * DIM_W;
	localparam int SEQ_AW = (LIN_W > IDX_W) ? LIN_W : IDX_W;
	localparam int TOP_W  = CHAN_W + WGT_W;
	localparam int SUM_W  = CHAN_W + 2 * WGT_W + 1;

	localparam logic [FRAC_W+DIM_W-1:0] HALF_TEXEL = (FRAC_W + DIM_W)'(1) << (FRAC_W - 1);
	localparam logic [COORD_W-1:0]      COORD_ONE  = COORD_W'(1) << FRAC_W;
	localparam logic [WGT_W:0]          WGT_FULL   = (WGT_W + 1)'(1) << WGT_W;
	localparam logic [SUM_W-1:0]        SUM_ROUND  = SUM_W'(1) << (2 * WGT_W - 1);
	localparam logic [TEXEL_W-1:0]      TEXEL_WHITE = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_ENABLE,
		REG_MODE
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_WHITE,
		OP_CLAMP,
		OP_BILIN
	} op_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             enable;
		logic             mode;
	} cfg_t;

	typedef struct packed {
		logic                      req_type;
		logic [IDX_W-1:0]          texel_index;
		logic [TEXEL_W-1:0]        texel_rgba;
		logic signed [COORD_W-1:0] coord_u;
		logic signed [COORD_W-1:0] coord_v;
	} req_t;

	typedef struct packed {
		op_t                op;
		logic [DIM_W-1:0]   x0;
		logic [DIM_W-1:0]   x1;
		logic [DIM_W-1:0]   y0;
		logic [DIM_W-1:0]   y1;
		logic [DIM_W-1:0]   w;
		logic [WGT_W-1:0]   wx;
		logic [WGT_W-1:0]   wy;
		logic [IDX_W-1:0]   wr_index;
		logic [TEXEL_W-1:0] wr_data;
	} coord_t;

	typedef struct packed {
		logic             last;
		op_t              op;
		logic             zero;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wy;
	} beat_t;

	typedef struct packed {
		logic [DIM_W-1:0] i0;
		logic [DIM_W-1:0] i1;
		logic [WGT_W-1:0] w;
	} axis_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
		if (int'(d) > MAX_DIM)
			return DIM_W'(MAX_DIM);
		return DIM_W'(d);
	endfunction

	function automatic axis_t wrap_axis(input logic [FRAC_W-1:0] frac,
			input logic [DIM_W-1:0] size);
		logic [FRAC_W+DIM_W-1:0] prod;
		logic [FRAC_W+DIM_W-1:0] pos;
		logic [FRAC_W-1:0]       f;
		logic [DIM_W-1:0]        i0;
		logic [FRAC_W+WGT_W-1:0] fw;
		axis_t                   r;
		prod = frac * size;
		pos  = prod - HALF_TEXEL;
		if (prod < HALF_TEXEL) begin
			i0 = size - 1'b1;
			f  = FRAC_W'(prod + HALF_TEXEL);
		end else begin
			i0 = pos[FRAC_W+DIM_W-1:FRAC_W];
			f  = pos[FRAC_W-1:0];
			if (i0 >= size)
				i0 = size - 1'b1;
		end
		fw   = {f, {WGT_W{1'b0}}};
		r.w  = fw[FRAC_W+WGT_W-1:FRAC_W];
		r.i0 = i0;
		r.i1 = (({1'b0, i0} + (DIM_W + 1)'(1)) >= {1'b0, size}) ? '0 : i0 + 1'b1;
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_axis(input logic [COORD_W-1:0] coord,
			input logic [DIM_W-1:0] size);
		logic [FRAC_W:0]       c;
		logic [DIM_W-1:0]      sm1;
		logic [FRAC_W+DIM_W:0] p;
		if (coord[COORD_W-1])
			c = '0;
		else if (coord > COORD_ONE)
			c = COORD_ONE[FRAC_W:0];
		else
			c = coord[FRAC_W:0];
		sm1 = size - 1'b1;
		p   = c * sm1;
		return p[FRAC_W+DIM_W-1:FRAC_W];
	endfunction

endpackage

### rtl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: input stage, registers, store sequencer.
//
//  channel   signals                                          beat when
//  request   start busy req_type texel_index texel_rgba       start && !busy
//            coord_u coord_v
//  result    done color_r color_g color_b color_a             done (one cycle)
//  config    cfg_we cfg_index cfg_data                        cfg_we
//
// The single store port sets the rate: a wrap-mode sample reads all four texels of its quad,
// a clamp sample or a texel write takes one access, a white sample none. Requests overlap.
// Results come out in request order through the sequencer, store, blend and result registers.
// Reset clears registers and pipeline control; store contents are kept as is.
// busy holds requests off while the sequencer is still issuing store accesses.
// done has no handshake; the receiver cannot stall the block.
module bilinear_texture_sampler #(
	parameter int TEXEL_COUNT = bts_pkg::TEXEL_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [bts_pkg::IDX_W-1:0]     texel_index,
	input  logic [bts_pkg::TEXEL_W-1:0]   texel_rgba,
	input  logic signed [bts_pkg::COORD_W-1:0] coord_u,
	input  logic signed [bts_pkg::COORD_W-1:0] coord_v,
	input  logic                          cfg_we,
	input  logic [bts_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bts_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output logic [bts_pkg::CHAN_W-1:0]    color_r,
	output logic [bts_pkg::CHAN_W-1:0]    color_g,
	output logic [bts_pkg::CHAN_W-1:0]    color_b,
	output logic [bts_pkg::CHAN_W-1:0]    color_a
);
	import bts_pkg::*;

	localparam int MEM_AW = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;

	cfg_t               cfg_q;

	logic               accept;
	logic               s2_take;
	logic               valid_s1;
	req_t               req_s1;
	logic               valid_s2;
	coord_t             coord_s2;

	logic [2:0]         seq_left_q;
	op_t                seq_op_q;
	logic [WGT_W-1:0]   seq_wx_q;
	logic [WGT_W-1:0]   seq_wy_q;
	logic [TEXEL_W-1:0] seq_wdata_q;
	logic [SEQ_AW-1:0]  seq_addr_q [4];
	logic [3:0]         seq_ok_q;
	logic               seq_issue;
	logic               seq_load;

	logic [LIN_W-1:0]   row0;
	logic [LIN_W-1:0]   row1;
	logic [SEQ_AW-1:0]  ld_addr [4];
	logic [3:0]         ld_ok;

	logic               mem_en;
	logic               mem_we;
	logic [TEXEL_W-1:0] mem_rdata;

	logic               valid_s4;
	beat_t              beat_s4;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  cfg_q.width  <= eff_dim(cfg_data);
				REG_HEIGHT: cfg_q.height <= eff_dim(cfg_data);
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_MODE:   cfg_q.mode   <= cfg_data[0];
			endcase
		end
	end

	// request and coordinate stages
	assign seq_issue = seq_left_q != 3'd0;
	assign seq_load  = valid_s2 && seq_left_q <= 3'd1;
	assign s2_take   = !valid_s2 || seq_load;
	assign busy      = valid_s1 && !s2_take;
	assign accept    = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type    <= req_type;
			req_s1.texel_index <= texel_index;
			req_s1.texel_rgba  <= texel_rgba;
			req_s1.coord_u     <= coord_u;
			req_s1.coord_v     <= coord_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s2_take);
			if (s2_take)
				valid_s2 <= valid_s1;
		end
	end

	bts_coord u_coord (
		.clk      (clk),
		.en       (s2_take),
		.req_s1   (req_s1),
		.cfg      (cfg_q),
		.coord_s2 (coord_s2)
	);

	// store sequencer: one access per cycle, quad order 00, 10, 01, 11
	always_comb begin
		row0 = coord_s2.y0 * coord_s2.w;
		row1 = coord_s2.y1 * coord_s2.w;
		if (coord_s2.op == OP_WRITE)
			ld_addr[0] = SEQ_AW'(coord_s2.wr_index);
		else
			ld_addr[0] = SEQ_AW'(row0 + coord_s2.x0);
		ld_addr[1] = SEQ_AW'(row0 + coord_s2.x1);
		ld_addr[2] = SEQ_AW'(row1 + coord_s2.x0);
		ld_addr[3] = SEQ_AW'(row1 + coord_s2.x1);
		for (int i = 0; i < 4; i++)
			ld_ok[i] = 32'(ld_addr[i]) < 32'(TEXEL_COUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_left_q <= 3'd0;
		else if (seq_load)
			seq_left_q <= (coord_s2.op == OP_BILIN) ? 3'd4 : 3'd1;
		else if (seq_issue)
			seq_left_q <= seq_left_q - 3'd1;
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			seq_op_q    <= coord_s2.op;
			seq_wx_q    <= coord_s2.wx;
			seq_wy_q    <= coord_s2.wy;
			seq_wdata_q <= coord_s2.wr_data;
			seq_addr_q  <= ld_addr;
			seq_ok_q    <= ld_ok;
		end else if (seq_issue) begin
			for (int i = 0; i < 3; i++)
				seq_addr_q[i] <= seq_addr_q[i+1];
			seq_ok_q <= seq_ok_q >> 1;
		end
	end

	assign mem_en = seq_issue && seq_ok_q[0] && seq_op_q != OP_WHITE;
	assign mem_we = seq_op_q == OP_WRITE;

	bts_texmem #(
		.TEXEL_COUNT (TEXEL_COUNT),
		.ADDR_W      (MEM_AW)
	) u_texmem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (MEM_AW'(seq_addr_q[0])),
		.wdata (seq_wdata_q),
		.rdata (mem_rdata)
	);

	// beat tag lines up with the store's read data
	always_ff @(posedge clk) begin
		if (seq_issue) begin
			beat_s4.last <= seq_left_q == 3'd1;
			beat_s4.op   <= seq_op_q;
			beat_s4.zero <= !seq_ok_q[0];
			beat_s4.wx   <= seq_wx_q;
			beat_s4.wy   <= seq_wy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else
			valid_s4 <= seq_issue && seq_op_q != OP_WRITE;
	end

	bts_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.beat_s4  (beat_s4),
		.rdata    (mem_rdata),
		.done     (done),
		.color_r  (color_r),
		.color_g  (color_g),
		.color_b  (color_b),
		.color_a  (color_a)
	);

	a_seq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_issue && !seq_load) |=> (seq_left_q == $past(seq_left_q) - 3'd1))
		else $error("sequencer count skipped a beat");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !seq_load) |=> (valid_s2 && $stable(coord_s2)))
		else $error("coordinate stage lost or changed a held item");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s4 && beat_s4.last, 2))
		else $error("result without a finished texel beat");

endmodule

### rtl/bts_coord.sv
// Coordinate stage: request decode, wrap and clamp axis math, stage-2 register.
module bts_coord (
	input  logic            clk,
	input  logic            en,
	input  bts_pkg::req_t   req_s1,
	input  bts_pkg::cfg_t   cfg,
	output bts_pkg::coord_t coord_s2
);
	import bts_pkg::*;

	logic             white;
	axis_t            ax;
	axis_t            ay;
	logic [DIM_W-1:0] cx;
	logic [DIM_W-1:0] cy;
	coord_t           nxt;

	always_comb begin
		white = !cfg.enable || cfg.width == '0 || cfg.height == '0;
		ax    = wrap_axis(req_s1.coord_u[FRAC_W-1:0], cfg.width);
		ay    = wrap_axis(req_s1.coord_v[FRAC_W-1:0], cfg.height);
		cx    = clamp_axis(req_s1.coord_u, cfg.width);
		cy    = clamp_axis(req_s1.coord_v, cfg.height);
		nxt          = '0;
		nxt.w        = cfg.width;
		nxt.wr_index = req_s1.texel_index;
		nxt.wr_data  = req_s1.texel_rgba;
		if (!req_s1.req_type) begin
			nxt.op = OP_WRITE;
		end else if (white) begin
			nxt.op = OP_WHITE;
		end else if (cfg.mode) begin
			nxt.op = OP_CLAMP;
			nxt.x0 = cx;
			nxt.y0 = cy;
		end else begin
			nxt.op = OP_BILIN;
			nxt.x0 = ax.i0;
			nxt.x1 = ax.i1;
			nxt.y0 = ay.i0;
			nxt.y1 = ay.i1;
			nxt.wx = ax.w;
			nxt.wy = ay.w;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			coord_s2 <= nxt;
	end

endmodule

### rtl/bts_texmem.sv
// Single-port texel store, one access per cycle, registered read data.
module bts_texmem #(
	parameter int TEXEL_COUNT = bts_pkg::TEXEL_COUNT_DEF,
	parameter int ADDR_W      = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           addr,
	input  logic [bts_pkg::TEXEL_W-1:0] wdata,
	output logic [bts_pkg::TEXEL_W-1:0] rdata
);
	import bts_pkg::*;

	logic [TEXEL_W-1:0] mem_q [TEXEL_COUNT];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem_q[addr] <= wdata;
			else
				rdata <= mem_q[addr];
		end
	end

endmodule

### rtl/bts_blend.sv
// Texel gather and two-stage bilinear blend with rounding, result register.
module bts_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s4,
	input  bts_pkg::beat_t              beat_s4,
	input  logic [bts_pkg::TEXEL_W-1:0] rdata,
	output logic                        done,
	output logic [bts_pkg::CHAN_W-1:0]  color_r,
	output logic [bts_pkg::CHAN_W-1:0]  color_g,
	output logic [bts_pkg::CHAN_W-1:0]  color_b,
	output logic [bts_pkg::CHAN_W-1:0]  color_a
);
	import bts_pkg::*;

	logic [TEXEL_W-1:0] data;
	logic [TEXEL_W-1:0] gath_q [3];
	logic [TEXEL_W-1:0] tx [4];
	logic [WGT_W:0]     wxc;
	logic [WGT_W:0]     wyc;
	logic [TOP_W-1:0]   top_c [CHANNELS];
	logic [TOP_W-1:0]   bot_c [CHANNELS];
	logic [SUM_W-1:0]   sum_c [CHANNELS];
	logic [CHAN_W:0]    res_c [CHANNELS];

	logic               valid_s5;
	logic [TOP_W-1:0]   top_s5 [CHANNELS];
	logic [TOP_W-1:0]   bot_s5 [CHANNELS];
	logic [WGT_W-1:0]   wy_s5;

	logic               done_q;
	logic [CHAN_W-1:0]  color_q [CHANNELS];

	always_comb begin
		if (beat_s4.op == OP_WHITE)
			data = TEXEL_WHITE;
		else if (beat_s4.zero)
			data = '0;
		else
			data = rdata;
		if (beat_s4.op == OP_BILIN) begin
			tx[0] = gath_q[0];
			tx[1] = gath_q[1];
			tx[2] = gath_q[2];
			tx[3] = data;
		end else begin
			for (int i = 0; i < 4; i++)
				tx[i] = data;
		end
		wxc = WGT_FULL - {1'b0, beat_s4.wx};
		wyc = WGT_FULL - {1'b0, wy_s5};
		for (int ch = 0; ch < CHANNELS; ch++) begin
			top_c[ch] = tx[0][TEXEL_W-1-CHAN_W*ch -: CHAN_W] * wxc
				+ tx[1][TEXEL_W-1-CHAN_W*ch -: CHAN_W] * beat_s4.wx;
			bot_c[ch] = tx[2][TEXEL_W-1-CHAN_W*ch -: CHAN_W] * wxc
				+ tx[3][TEXEL_W-1-CHAN_W*ch -: CHAN_W] * beat_s4.wx;
			sum_c[ch] = top_s5[ch] * wyc + bot_s5[ch] * wy_s5 + SUM_ROUND;
			res_c[ch] = sum_c[ch][SUM_W-1:2*WGT_W];
		end
	end

	// earlier texels of a quad shift in, the last one comes straight from the store
	always_ff @(posedge clk) begin
		if (valid_s4 && !beat_s4.last) begin
			gath_q[0] <= gath_q[1];
			gath_q[1] <= gath_q[2];
			gath_q[2] <= data;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && beat_s4.last) begin
			top_s5 <= top_c;
			bot_s5 <= bot_c;
			wy_s5  <= beat_s4.wy;
		end
		if (valid_s5) begin
			for (int ch = 0; ch < CHANNELS; ch++)
				color_q[ch] <= res_c[ch][CHAN_W] ? '1 : res_c[ch][CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s5 <= valid_s4 && beat_s4.last;
			done_q   <= valid_s5;
		end
	end

	assign done    = done_q;
	assign color_r = color_q[0];
	assign color_g = color_q[1];
	assign color_b = color_q[2];
	assign color_a = color_q[3];

endmodule
